/* rtl/pcet_pkg.sv */
// Package for the pin change event timestamper: widths, reset values and
// payload types shared by the interfaces, the controller and the datapath.
package pcet_pkg;
   localparam int FRAME_W = 64;
   localparam int TIME_W = 63;
   localparam int PERIOD_W = 32;
   localparam int OFFSET_W = 8;
   localparam int DEF_NUM_CHANNELS = 4;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd22676;

   typedef struct packed {
      logic                    load;      // capture input item
      logic                    sync_upd;  // shift sync points
      logic                    mul_start; // start interpolation multiply
      logic                    mul_step;
      logic                    div_start;
      logic                    div_step;
      logic                    base_interp; // latch interpolated time into base
      logic                    base_newer;  // latch newer sync time into base
      logic                    time_calc;   // form the frame time
      logic                    emit;        // load an event into the output stage
   } pcet_cmd_type;

   typedef struct packed {
      logic kind;
      logic block_start;
      logic span_zero;
      logic changes;     // some channel still differs
   } pcet_sts_type;
endpackage

/* rtl/pcet_req_if.sv */
// Input channel interface of the pin change event timestamper.
// Depends on pcet_pkg.
interface pcet_req_if;
   import pcet_pkg::*;
   logic                kind;
   logic [FRAME_W-1:0]  frame_number;
   logic                block_start;
   logic [OFFSET_W-1:0] frame_offset;
   logic [3:0]          pin_levels;
   logic [TIME_W-1:0]   sync_time_ns;
   logic                valid;
   logic                ready;
   modport source (output kind, frame_number, block_start, frame_offset, pin_levels,
                   sync_time_ns, valid, input ready);
   modport sink (input kind, frame_number, block_start, frame_offset, pin_levels,
                 sync_time_ns, valid, output ready);
endinterface

/* rtl/pcet_rsp_if.sv */
// Result channel interface of the pin change event timestamper.
// Depends on pcet_pkg.
interface pcet_rsp_if;
   import pcet_pkg::*;
   logic               valid;
   logic               ready;
   logic [FRAME_W-1:0] event_frame;
   logic [1:0]         channel;
   logic               level;
   logic [3:0]         snapshot;
   logic [TIME_W-1:0]  event_time_ns;
   logic               last;
   modport source (output valid, event_frame, channel, level, snapshot, event_time_ns,
                   last, input ready);
   modport sink (input valid, event_frame, channel, level, snapshot, event_time_ns,
                 last, output ready);
endinterface

/* rtl/pin_change_event_timestamper_unit.sv */
// Top level of the pin change event timestamper. Depends on pcet_pkg, the
// channel interfaces, pcet_ctrl and pcet_dp.
//
// A sync transfer passes the idle and decode states. A frame transfer without
// block start, or with a zero frame span, passes idle, decode and time and
// then emits its events while the result side keeps up; a block start with a
// nonzero frame span adds a four-step 32x32 multiply and a one-bit-per-cycle
// 128/64 divider. Events leave through a registered output stage; the input is
// held off while events of a frame remain to be loaded into that stage.
module pin_change_event_timestamper_unit #(
   parameter int NUM_CHANNELS = pcet_pkg::DEF_NUM_CHANNELS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [pcet_pkg::PERIOD_W-1:0]  csr_write_data,
   pcet_req_if.sink                       req,
   pcet_rsp_if.source                     rsp
);
   import pcet_pkg::*;
   logic [PERIOD_W-1:0] period_ff;
   pcet_cmd_type cmd;
   pcet_sts_type sts;
   logic out_busy;

   always_ff @(posedge clock) begin
      if (reset) period_ff <= PERIOD_RESET;
      else if (csr_write_enable) period_ff <= csr_write_data;
   end

   pcet_ctrl u_ctrl (
      .clock, .reset, .in_valid(req.valid), .in_ready(req.ready),
      .out_busy, .sts, .cmd
   );

   pcet_dp #(.NUM_CHANNELS(NUM_CHANNELS)) u_dp (
      .clock, .reset, .cmd, .sts, .out_busy, .period(period_ff),
      .in_kind(req.kind), .in_frame(req.frame_number), .in_start(req.block_start),
      .in_offset(req.frame_offset), .in_levels(req.pin_levels),
      .in_stime(req.sync_time_ns),
      .o_valid(rsp.valid), .o_ready(rsp.ready), .o_frame(rsp.event_frame),
      .o_channel(rsp.channel), .o_level(rsp.level), .o_snapshot(rsp.snapshot),
      .o_time(rsp.event_time_ns), .o_last(rsp.last)
   );
endmodule

/* rtl/pcet_ctrl.sv */
// Controller of the pin change event timestamper: sequences sync updates,
// the iterative multiply and divide, and event emission. Depends on pcet_pkg.
module pcet_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic                   out_busy,
   input  pcet_pkg::pcet_sts_type sts,
   output pcet_pkg::pcet_cmd_type cmd
);
   import pcet_pkg::*;
   localparam logic [2:0] S_IDLE = 3'd0, S_DEC = 3'd1, S_MUL = 3'd2, S_DIV = 3'd3,
                          S_BASE = 3'd4, S_TIME = 3'd5, S_EMIT = 3'd6;
   logic [2:0] state_ff, state_in;
   logic [6:0] cnt_ff, cnt_in;

   assign in_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (sts.kind) begin
               cmd.sync_upd = 1'b1;
               state_in = S_IDLE;
            end else if (!sts.block_start) begin
               state_in = S_TIME;
            end else if (sts.span_zero) begin
               cmd.base_newer = 1'b1;
               state_in = S_TIME;
            end else begin
               cmd.mul_start = 1'b1;
               cnt_in = 7'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd3) begin
               state_in = S_DIV;
               cnt_in = 7'd0;
            end
         end
         S_DIV: begin
            if (cnt_ff == 7'd0) cmd.div_start = 1'b1;
            else cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd64) state_in = S_BASE;
         end
         S_BASE: begin
            cmd.base_interp = 1'b1;
            state_in = S_TIME;
         end
         S_TIME: begin
            cmd.time_calc = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!sts.changes) state_in = S_IDLE;
            else if (!out_busy) cmd.emit = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

/* rtl/pcet_dp.sv */
// Datapath of the pin change event timestamper: sync points, a four-step
// 32x32 multiplier, a radix-2 divider, frame time and event output stage.
// Depends on pcet_pkg.
module pcet_dp #(
   parameter int NUM_CHANNELS = pcet_pkg::DEF_NUM_CHANNELS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pcet_pkg::pcet_cmd_type          cmd,
   output pcet_pkg::pcet_sts_type          sts,
   output logic                            out_busy,
   input  logic [pcet_pkg::PERIOD_W-1:0]   period,
   input  logic                            in_kind,
   input  logic [pcet_pkg::FRAME_W-1:0]    in_frame,
   input  logic                            in_start,
   input  logic [pcet_pkg::OFFSET_W-1:0]   in_offset,
   input  logic [3:0]                      in_levels,
   input  logic [pcet_pkg::TIME_W-1:0]     in_stime,
   output logic                            o_valid,
   input  logic                            o_ready,
   output logic [pcet_pkg::FRAME_W-1:0]    o_frame,
   output logic [1:0]                      o_channel,
   output logic                            o_level,
   output logic [3:0]                      o_snapshot,
   output logic [pcet_pkg::TIME_W-1:0]     o_time,
   output logic                            o_last
);
   import pcet_pkg::*;
   localparam int NCH = (NUM_CHANNELS < 4) ? NUM_CHANNELS : 4;
   localparam logic [3:0] CH_MASK = 4'((5'd1 << NCH) - 5'd1);

   logic              kind_ff, start_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic [3:0]        levels_ff, stored_ff;
   logic [TIME_W-1:0] stime_ff;
   logic [FRAME_W-1:0] of_ff, nf_ff;
   logic [TIME_W-1:0] ot_ff, nt_ff, base_ff, time_ff;
   logic              up_ff;
   logic [FRAME_W-1:0] d_ff;
   logic [TIME_W-1:0] mag_ff;
   logic [127:0]      prod_ff;
   logic [63:0]       rem_ff, q_ff, lo_ff, span_ff;
   logic [1:0]        mstep_ff;
   logic [FRAME_W-1:0] span, dd;
   logic [64:0]       rem_sh;
   logic [31:0]       mul_a, mul_b;
   logic [63:0]       pp;
   logic [127:0]      pp_sh;
   logic [3:0]        diff;
   logic [1:0]        ch;
   logic [3:0]        rest;
   logic [63:0]       tsum;
   logic [39:0]       add;

   assign span = nf_ff - of_ff;
   assign dd = frame_ff - of_ff;
   assign diff = (levels_ff ^ stored_ff) & CH_MASK;
   assign sts.kind = kind_ff;
   assign sts.block_start = start_ff;
   assign sts.span_zero = (span == '0);
   assign sts.changes = (diff != 4'd0);
   assign out_busy = o_valid && !o_ready;

   always_comb begin
      ch = 2'd3;
      for (int i = 3; i >= 0; i--) if (diff[i]) ch = 2'(i);
      rest = diff & ~(4'd1 << ch);
   end

   assign mul_a = mstep_ff[0] ? d_ff[63:32] : d_ff[31:0];
   assign mul_b = mstep_ff[1] ? {1'b0, mag_ff[62:32]} : mag_ff[31:0];
   assign pp = {32'd0, mul_a} * {32'd0, mul_b};

   always_comb begin
      case (mstep_ff)
         2'd0: pp_sh = {64'd0, pp};
         2'd3: pp_sh = {pp, 64'd0};
         default: pp_sh = {32'd0, pp, 32'd0};
      endcase
   end

   assign rem_sh = {rem_ff, lo_ff[63]};
   assign add = {32'd0, offset_ff} * {8'd0, period};
   assign tsum = {1'b0, base_ff} + {24'd0, add};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= in_kind;
         frame_ff <= in_frame;
         start_ff <= in_start;
         offset_ff <= in_offset;
         levels_ff <= in_levels;
         stime_ff <= in_stime;
      end
      if (cmd.mul_start) begin
         d_ff <= (dd > span) ? span : dd;
         up_ff <= (nt_ff >= ot_ff);
         mag_ff <= (nt_ff >= ot_ff) ? nt_ff - ot_ff : ot_ff - nt_ff;
         span_ff <= span;
         prod_ff <= '0;
         mstep_ff <= '0;
      end
      if (cmd.mul_step) begin
         prod_ff <= prod_ff + pp_sh;
         mstep_ff <= mstep_ff + 2'd1;
      end
      if (cmd.div_start) begin
         rem_ff <= prod_ff[127:64];
         lo_ff <= prod_ff[63:0];
         q_ff <= '0;
      end
      if (cmd.div_step) begin
         lo_ff <= {lo_ff[62:0], 1'b0};
         if (rem_sh >= {1'b0, span_ff}) begin
            rem_ff <= 64'(rem_sh - {1'b0, span_ff});
            q_ff <= {q_ff[62:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[63:0];
            q_ff <= {q_ff[62:0], 1'b0};
         end
      end
      if (cmd.time_calc) time_ff <= tsum[63] ? {TIME_W{1'b1}} : tsum[TIME_W-1:0];
      if (cmd.emit) begin
         o_frame <= frame_ff;
         o_channel <= ch;
         o_level <= levels_ff[ch];
         o_snapshot <= stored_ff ^ (4'd1 << ch);
         o_time <= time_ff;
         o_last <= (rest == 4'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff <= '0;
         of_ff <= '0;
         ot_ff <= '0;
         nf_ff <= '0;
         nt_ff <= '0;
         base_ff <= '0;
         o_valid <= 1'b0;
      end else begin
         if (cmd.sync_upd) begin
            of_ff <= nf_ff;
            ot_ff <= nt_ff;
            nf_ff <= frame_ff;
            nt_ff <= stime_ff;
         end
         if (cmd.base_newer) base_ff <= nt_ff;
         if (cmd.base_interp)
            base_ff <= up_ff ? ot_ff + q_ff[TIME_W-1:0] : ot_ff - q_ff[TIME_W-1:0];
         if (cmd.emit) begin
            stored_ff <= stored_ff ^ (4'd1 << ch);
            o_valid <= 1'b1;
         end else if (o_ready) begin
            o_valid <= 1'b0;
         end
      end
   end
endmodule

/* test/pin_change_event_timestamper_unit_tb.sv */
// Testbench for pin_change_event_timestamper_unit: drives sync and frame transfers,
// predicts every level change event with its interpolated time and checks each result.
// Depends on pcet_pkg, pcet_req_if, pcet_rsp_if and the block itself.
`timescale 1ns / 1ps

module pin_change_event_timestamper_unit_tb;
   import pcet_pkg::*;

   localparam logic        KIND_FRAME = 1'b0;
   localparam logic        KIND_SYNC = 1'b1;
   localparam logic [62:0] TIME_MAX = {63{1'b1}};

   typedef struct {
      logic                kind;
      logic [FRAME_W-1:0]  frame_number;
      logic                block_start;
      logic [OFFSET_W-1:0] frame_offset;
      logic [3:0]          pin_levels;
      logic [TIME_W-1:0]   sync_time_ns;
   } stamp_req_type;

   typedef struct {
      logic [FRAME_W-1:0] event_frame;
      logic [1:0]         channel;
      logic               level;
      logic [3:0]         snapshot;
      logic [TIME_W-1:0]  event_time_ns;
      logic               last;
   } pin_event_type;

   class event_scoreboard_type;
      logic [PERIOD_W-1:0] period;
      logic [3:0]          levels;
      logic [FRAME_W-1:0]  old_frame, new_frame;
      logic [TIME_W-1:0]   old_time, new_time, base_time;
      pin_event_type       pending_events[$];
      int                  mismatches;

      function void clear();
         period = PERIOD_RESET;
         levels = '0;
         old_frame = '0;
         new_frame = '0;
         old_time = '0;
         new_time = '0;
         base_time = '0;
         pending_events.delete();
         mismatches = 0;
      endfunction

      function logic [TIME_W-1:0] interpolated_time(logic [FRAME_W-1:0] f);
         logic [63:0]  span, d;
         logic [62:0]  mag;
         logic [127:0] q;
         span = new_frame - old_frame;
         d = f - old_frame;
         if (span == 0) return new_time;
         if (d > span) d = span;
         mag = (new_time >= old_time) ? new_time - old_time : old_time - new_time;
         q = (128'(d) * 128'(mag)) / 128'(span);
         return (new_time >= old_time) ? old_time + q[62:0] : old_time - q[62:0];
      endfunction

      function void note_input(stamp_req_type r);
         logic [63:0]   t;
         pin_event_type e;
         int            first;
         if (r.kind == KIND_SYNC) begin
            old_frame = new_frame;
            old_time = new_time;
            new_frame = r.frame_number;
            new_time = r.sync_time_ns;
            return;
         end
         if (r.block_start) base_time = interpolated_time(r.frame_number);
         t = {1'b0, base_time} + 64'(r.frame_offset) * 64'(period);
         if (t > {1'b0, TIME_MAX}) t = {1'b0, TIME_MAX};
         first = pending_events.size();
         for (int i = 0; i < 4; i++) begin
            if (r.pin_levels[i] != levels[i]) begin
               levels[i] = r.pin_levels[i];
               e.event_frame = r.frame_number;
               e.channel = 2'(i);
               e.level = r.pin_levels[i];
               e.snapshot = levels;
               e.event_time_ns = t[62:0];
               e.last = 1'b0;
               pending_events.insert(pending_events.size(), e);
            end
         end
         if (pending_events.size() > first)
            pending_events[pending_events.size() - 1].last = 1'b1;
      endfunction

      function void check_result(pin_event_type a);
         pin_event_type x;
         if (pending_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected event: frame %h channel %0d", a.event_frame, a.channel);
            return;
         end
         x = pending_events.pop_front();
         if (a.event_frame !== x.event_frame || a.channel !== x.channel ||
             a.level !== x.level || a.snapshot !== x.snapshot ||
             a.event_time_ns !== x.event_time_ns || a.last !== x.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Event mismatch: expected frame %h ch %0d lvl %b snap %h time %h last %b",
                        x.event_frame, x.channel, x.level, x.snapshot, x.event_time_ns,
                        x.last);
               $display("                got      frame %h ch %0d lvl %b snap %h time %h last %b",
                        a.event_frame, a.channel, a.level, a.snapshot, a.event_time_ns,
                        a.last);
            end
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [PERIOD_W-1:0]  csr_write_data;
   bit                   idling_on;
   int                   hold_cycles = 0;
   int                   ready_stall = 0;
   event_scoreboard_type sb;

   pcet_req_if req_bus ();
   pcet_rsp_if rsp_bus ();

   pin_change_event_timestamper_unit uut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req(req_bus.sink),
      .rsp(rsp_bus.source)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

   // Receiver side: random stalls plus an optional long hold-off.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_bus.ready = 1'b0;
      end else if (ready_stall > 0) begin
         ready_stall = ready_stall - 1;
         rsp_bus.ready = 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         ready_stall = $urandom_range(1, 12) - 1;
         rsp_bus.ready = 1'b0;
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      pin_event_type a;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         a.event_frame = rsp_bus.event_frame;
         a.channel = rsp_bus.channel;
         a.level = rsp_bus.level;
         a.snapshot = rsp_bus.snapshot;
         a.event_time_ns = rsp_bus.event_time_ns;
         a.last = rsp_bus.last;
         sb.check_result(a);
      end
   end

   task automatic send_item(stamp_req_type r);
      int gap;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.kind = r.kind;
      req_bus.frame_number = r.frame_number;
      req_bus.block_start = r.block_start;
      req_bus.frame_offset = r.frame_offset;
      req_bus.pin_levels = r.pin_levels;
      req_bus.sync_time_ns = r.sync_time_ns;
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_input(r);
   endtask

   task automatic send_sync(logic [63:0] f, logic [62:0] t);
      stamp_req_type r;
      r.kind = KIND_SYNC;
      r.frame_number = f;
      r.sync_time_ns = t;
      r.block_start = 1'($urandom_range(0, 1));
      r.frame_offset = 8'($urandom);
      r.pin_levels = 4'($urandom);
      send_item(r);
   endtask

   task automatic send_frame(logic [63:0] f, logic bs, logic [7:0] off, logic [3:0] lv);
      stamp_req_type r;
      r.kind = KIND_FRAME;
      r.frame_number = f;
      r.block_start = bs;
      r.frame_offset = off;
      r.pin_levels = lv;
      r.sync_time_ns = 63'({$urandom, $urandom});
      send_item(r);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (sb.pending_events.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_period(logic [31:0] v);
      wait_idle();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = v;
      @(posedge clock);
      sb.period = v;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic send_noise();
      stamp_req_type r;
      r.kind = 1'($urandom_range(0, 1));
      r.frame_number = {$urandom, $urandom};
      r.block_start = 1'($urandom_range(0, 1));
      r.frame_offset = 8'($urandom);
      r.pin_levels = 4'($urandom);
      r.sync_time_ns = 63'({$urandom, $urandom});
      send_item(r);
   endtask

   // A sync pair followed by one render block of frames.
   task automatic send_block();
      logic [63:0] f0, f1;
      logic [62:0] t0;
      int          n, span;
      f0 = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom);
      t0 = ($urandom_range(0, 3) == 0) ? 63'({$urandom, $urandom})
                                       : 63'({$urandom, $urandom} >> 20);
      span = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4096);
      send_sync(f0, t0);
      send_sync(f0 + 64'(span), t0 + 63'($urandom_range(0, 200000)) - 63'(100000));
      f1 = f0 + 64'($urandom_range(0, span + 200)) - 64'($urandom_range(0, 20));
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) send_frame(f1 + 64'(i), i == 0, 8'(i), 4'($urandom));
   endtask

   initial begin
      sb = new();
      sb.clear();
      idling_on = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_FRAME;
      req_bus.frame_number = '0;
      req_bus.block_start = 1'b0;
      req_bus.frame_offset = '0;
      req_bus.pin_levels = '0;
      req_bus.sync_time_ns = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_frame(64'd7, 1'b0, 8'd3, 4'hF);
      send_frame(64'd8, 1'b1, 8'd0, 4'h0);
      send_sync(64'd0, 63'd1000);
      send_sync(64'd100, 63'd2000);
      send_frame(64'd50, 1'b1, 8'd0, 4'h1);
      send_frame(64'd51, 1'b0, 8'd1, 4'h1);
      send_frame(64'd52, 1'b0, 8'd255, 4'hA);
      send_sync(64'd1000, 63'd5000);
      send_sync(64'd1100, 63'd4000);
      send_frame(64'd1030, 1'b1, 8'd0, 4'h5);
      send_frame(64'd900, 1'b1, 8'd0, 4'h6);
      send_sync(64'd1100, 63'd7000);
      send_frame(64'd2000, 1'b1, 8'd2, 4'h9);
      write_period(32'hFFFF_FFFF);
      send_sync('1, TIME_MAX);
      send_sync('1, TIME_MAX);
      send_frame('1, 1'b1, 8'd255, 4'h0);
      send_frame(64'd0, 1'b0, 8'd0, 4'hF);
      write_period(32'd0);
      send_frame(64'h8000_0000_0000_0000, 1'b0, 8'd200, 4'h3);
      send_sync(64'd0, 63'd0);
      send_frame('1, 1'b1, 8'd1, 4'hC);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_period(32'd22676);
            1: write_period($urandom);
            2: write_period(32'hFFFF_FFFF);
            3: write_period(32'd0);
            4: write_period($urandom_range(1, 100000));
            default: begin
               write_period(32'd20833);
               idling_on = 1'b0;
            end
         endcase
         if (phase == 2) begin
            @(negedge clock);
            hold_cycles = 400;
            for (int i = 0; i < 30; i++) send_frame(64'(i), 1'b0, 8'(i), ~sb.levels);
         end
         for (int k = 0; k < 7; k++) begin
            if ($urandom_range(0, 5) == 0) send_noise();
            else send_block();
         end
      end

      wait_idle();
      if (sb.mismatches == 0 && sb.pending_events.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
